/* design/median_window_fast_outlier_detector_unit_defines.svh */
// Assertion macros for the median window fast outlier detector.
// Used by the port checker; no other dependencies.
`ifndef MEDIAN_WINDOW_FAST_OUTLIER_DETECTOR_UNIT_DEFINES_SVH
`define MEDIAN_WINDOW_FAST_OUTLIER_DETECTOR_UNIT_DEFINES_SVH

// antecedent holds, consequent holds in the next cycle
`define MWFO_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("mwfo check failed");

// antecedent holds, consequent holds in the same cycle
`define MWFO_ASSERT_NOW(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("mwfo check failed");

`endif

/* design/mwfo_pkg.sv */
// Shared types and constants for the median window fast outlier detector.
// No dependencies.
`default_nettype none
package mwfo_pkg;
  localparam int LAP_W     = 32;
  localparam int PCT_W     = 7;
  localparam int DEPTH_W   = 7;
  localparam int PROD_W    = LAP_W + PCT_W;
  localparam int CFG_AW    = 2;
  localparam int OUT_W     = 40;
  localparam int MIN_JUDGE = 4;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_WINDOW_DEPTH = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FAST_MARGIN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FAST_RATIO   = 2'd2;

  // control shared by all sorter cells
  typedef struct packed {
    logic clr;
    logic shift;
  } sort_ctrl_t;
endpackage
`default_nettype wire

/* design/mwfo_sort_cell.sv */
// One cell of the systolic insertion sorter: keeps the smaller value, passes
// the larger to its neighbor; in shift mode moves toward cell 0. Uses mwfo_pkg.
`default_nettype none
module mwfo_sort_cell
  import mwfo_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sort_ctrl_t       ctrl,
  input  wire logic             din_v,
  input  wire logic [LAP_W-1:0] din,
  input  wire logic             nbr_vld,
  input  wire logic [LAP_W-1:0] nbr_val,
  output logic                  vld_r,
  output logic [LAP_W-1:0]      val_r,
  output logic                  dout_v_r,
  output logic [LAP_W-1:0]      dout_r
);
  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      vld_r    <= 1'b0;
      dout_v_r <= 1'b0;
    end else if (ctrl.shift) begin
      vld_r    <= nbr_vld;
      dout_v_r <= 1'b0;
    end else begin
      dout_v_r <= din_v && vld_r;
      if (din_v) vld_r <= 1'b1;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val_r <= nbr_val;
    end else if (din_v) begin
      if (!vld_r) begin
        val_r <= din;
      end else if (din < val_r) begin
        val_r  <= din;
        dout_r <= val_r;
      end else begin
        dout_r <= din;
      end
    end
  end
endmodule
`default_nettype wire

/* design/mwfo_div100.sv */
// Divider by one hundred: reciprocal multiplication, ten dividend bits per
// cycle, most significant chunk first. Uses mwfo_pkg.
`default_nettype none
module mwfo_div100
  import mwfo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  output logic                   done_r,
  output logic [PROD_W-1:0]      quot_r
);
  // floor(x / 100) = (x * RECIP) >> RECIP_SH, exact for x below 2**39
  localparam int CHUNK_W  = 10;
  localparam int NCHUNK   = 4;
  localparam int X_W      = CHUNK_W * NCHUNK;
  localparam int RECIP_W  = 40;
  localparam int RECIP_SH = 46;
  localparam int PART_W   = CHUNK_W + RECIP_W;
  localparam int ACC_W    = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = 40'd703687441777;

  logic [1:0]        step_r;
  logic              busy_r;
  logic [X_W-1:0]    x_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PART_W-1:0] part;
  logic [ACC_W-1:0]  acc_nxt;

  // top chunk times the reciprocal, added to the shifted running sum
  assign part    = PART_W'(x_r[X_W-1 -: CHUNK_W]) * PART_W'(RECIP);
  assign acc_nxt = (acc_r << CHUNK_W) + ACC_W'(part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'(NCHUNK - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend chunks out, product in
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= X_W'(dividend);
      acc_r <= '0;
    end else if (busy_r) begin
      x_r   <= x_r << CHUNK_W;
      acc_r <= acc_nxt;
      if (step_r == 2'(NCHUNK - 1)) quot_r <= PROD_W'(acc_nxt[ACC_W-1:RECIP_SH]);
    end
  end
endmodule
`default_nettype wire

/* design/median_window_fast_outlier_detector_unit.sv */
// Steps per item: gather scan, sorter settle, sorted drain and a four-step divide by 100;
// sort and divide are skipped when fewer than four laps qualify. One item at a time; the
// next is taken in the cycle after the result is registered.
// A result waiting in the full output register holds the block in its final state.
// Synchronous active-low reset clears fill count, FSM and output valid, presets config.
`default_nettype none
module median_window_fast_outlier_detector_unit
  import mwfo_pkg::*;
#(
  parameter int RING_CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [LAP_W-1:0]  in_tdata,   // [31:0] lap_time_ms
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // [0] is_outlier, [1] judged,
                                             // [33:2] window_median_ms, rest 0
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [LAP_W-1:0]  cfg_wdata
);
  localparam int AW = $clog2(RING_CAPACITY);
  localparam int CW = $clog2(RING_CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_GATHER = 7'b0000010,
    ST_SETTLE = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_MED    = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r;

  logic [DEPTH_W-1:0] window_depth_r;
  logic [LAP_W-1:0]   fast_margin_r;
  logic [PCT_W-1:0]   fast_ratio_r;

  logic [LAP_W-1:0] store_r [RING_CAPACITY];
  logic [CW-1:0]    fill_r;
  logic [LAP_W-1:0] lap_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    k_r;
  logic [LAP_W-1:0] lo_r, hi_r, med_r;
  logic             judged_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_depth_r <= DEPTH_W'(8);
      fast_margin_r  <= LAP_W'(1000);
      fast_ratio_r   <= PCT_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_DEPTH: window_depth_r <= cfg_wdata[DEPTH_W-1:0];
        REG_FAST_MARGIN:  fast_margin_r  <= cfg_wdata;
        REG_FAST_RATIO:   fast_ratio_r   <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective depth and ratio
  logic [CW-1:0]    depth_eff;
  logic [PCT_W-1:0] pct_eff;
  assign depth_eff = (window_depth_r > DEPTH_W'(RING_CAPACITY)) ? CW'(RING_CAPACITY)
                                                              : CW'(window_depth_r);
  assign pct_eff = (fast_ratio_r > PCT_SCALE) ? PCT_SCALE : fast_ratio_r;

  // gather step
  logic             gather_go;
  logic [LAP_W-1:0] gather_val;
  logic             push_v;
  assign gather_go  = (state_r == ST_GATHER) && (idx_r < fill_r) && (cnt_r < depth_eff);
  assign gather_val = store_r[idx_r[AW-1:0]];
  assign push_v     = gather_go && (gather_val != '0);

  // sorter chain
  sort_ctrl_t       sctrl;
  logic             s_vld  [RING_CAPACITY];
  logic [LAP_W-1:0] s_val  [RING_CAPACITY];
  logic             s_dv   [RING_CAPACITY];
  logic [LAP_W-1:0] s_d    [RING_CAPACITY];

  assign sctrl.clr   = (state_r == ST_IDLE);
  assign sctrl.shift = (state_r == ST_SHIFT);

  for (genvar g = 0; g < RING_CAPACITY; g++) begin : g_cell
    logic             c_dv, c_nv;
    logic [LAP_W-1:0] c_d, c_nval;
    if (g == 0) begin : g_head
      assign c_dv = push_v;
      assign c_d  = gather_val;
    end else begin : g_body
      assign c_dv = s_dv[g-1];
      assign c_d  = s_d[g-1];
    end
    if (g == RING_CAPACITY - 1) begin : g_tail
      assign c_nv   = 1'b0;
      assign c_nval = '0;
    end else begin : g_mid
      assign c_nv   = s_vld[g+1];
      assign c_nval = s_val[g+1];
    end
    mwfo_sort_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(sctrl),
      .din_v(c_dv), .din(c_d), .nbr_vld(c_nv), .nbr_val(c_nval),
      .vld_r(s_vld[g]), .val_r(s_val[g]), .dout_v_r(s_dv[g]), .dout_r(s_d[g])
    );
  end

  // median: the middle value for an odd count, else the floor of the two middle values' mean
  logic [LAP_W:0]   mid_sum;
  logic [LAP_W-1:0] med_calc;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign med_calc = cnt_r[0] ? hi_r : mid_sum[LAP_W:1];

  // ratio floor divider, started with the median as it is formed
  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  logic [PROD_W-1:0] product;
  assign product = PROD_W'(med_calc) * PROD_W'(pct_eff);

  mwfo_div100 u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == ST_MED && judged_r),
    .dividend(product), .done_r(div_done), .quot_r(div_quot)
  );

  // floor
  logic [CW-1:0]    half;
  logic [LAP_W-1:0] abs_floor, fast_floor;
  logic             outlier;
  assign half       = cnt_r >> 1;
  assign abs_floor  = (med_r > fast_margin_r) ? (med_r - fast_margin_r) : '0;
  assign fast_floor = (abs_floor > div_quot[LAP_W-1:0]) ? abs_floor : div_quot[LAP_W-1:0];
  assign outlier    = judged_r && (lap_r < fast_floor);

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_tvalid) begin
          lap_r    <= in_tdata;
          idx_r    <= '0;
          cnt_r    <= '0;
          judged_r <= 1'b0;
          med_r    <= '0;
          state_r  <= ST_GATHER;
        end
        ST_GATHER: begin
          if (gather_go) begin
            idx_r <= idx_r + 1'b1;
            if (push_v) cnt_r <= cnt_r + 1'b1;
          end else if (cnt_r >= CW'(MIN_JUDGE)) begin
            judged_r <= 1'b1;
            k_r      <= '0;
            state_r  <= ST_SETTLE;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_SETTLE: begin
          k_r <= k_r + 1'b1;
          if (k_r == CW'(RING_CAPACITY - 1)) begin
            k_r     <= '0;
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          k_r <= k_r + 1'b1;
          if (k_r == half - 1'b1) lo_r <= s_val[0];
          if (k_r == half) begin
            hi_r    <= s_val[0];
            state_r <= ST_MED;
          end
        end
        ST_MED: begin
          med_r   <= med_calc;
          state_r <= ST_DIV;
        end
        ST_DIV: if (div_done) state_r <= ST_DONE;
        ST_DONE: if (out_free) begin
          if (fill_r < CW'(RING_CAPACITY)) fill_r <= fill_r + 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // lap store: shift line, newest in entry 0
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      store_r[0] <= lap_r;
      for (int i = 1; i < RING_CAPACITY; i++) store_r[i] <= store_r[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {6'b0, med_r, judged_r, outlier};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

/* design/mwfo_port_checker.sv */
// Port-level checks for the median window fast outlier detector, bound to
// the top level. Uses mwfo_pkg and the assertion macro header.
`default_nettype none
`include "median_window_fast_outlier_detector_unit_defines.svh"
module mwfo_port_checker
  import mwfo_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  // a stalled result stays offered
  `MWFO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // one item at a time: busy right after an accept
  `MWFO_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a flagged lap was judged
  `MWFO_ASSERT_NOW(a_flag_needs_judge, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[1])
  // unjudged results carry a zero median
  `MWFO_ASSERT_NOW(a_zero_median, clk, rst_n, out_tvalid && !out_tdata[1],
                   out_tdata[33:2] == '0)
endmodule

bind median_window_fast_outlier_detector_unit mwfo_port_checker u_mwfo_port_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the median window fast outlier detector: drives lap times,
// predicts each flag and median in SystemVerilog, and checks every result.
// Depends on mwfo_pkg and median_window_fast_outlier_detector_unit.
`default_nettype none
module tb_top;
  import mwfo_pkg::*;

  localparam int CAP = 16;
  localparam int HOLD_LEN = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [LAP_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [LAP_W-1:0] cfg_wdata = '0;

  typedef struct packed {
    logic [LAP_W-1:0] median;
    logic judged;
    logic outlier;
  } verdict_t;

  // predictor state
  logic [LAP_W-1:0] lap_hist [CAP];
  int unsigned hist_pos = 0;
  int unsigned hist_fill = 0;
  logic [DEPTH_W-1:0] depth_reg = 7'd8;
  logic [LAP_W-1:0] margin_reg = 32'd1000;
  logic [PCT_W-1:0] ratio_reg = 7'd50;

  verdict_t verdict_q[$];
  int errors = 0;
  int hold_seq = 0;
  bit stall_enable = 1'b1;

  median_window_fast_outlier_detector_unit #(.RING_CAPACITY(CAP)) u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected verdict for one lap, then store the lap
  function automatic verdict_t judge_lap(logic [LAP_W-1:0] lap);
    logic [LAP_W-1:0] picked [$];
    logic [LAP_W-1:0] tmp;
    logic [63:0] prod;
    logic [LAP_W-1:0] abs_fl, rat_fl, fl;
    int unsigned lim, pct;
    verdict_t v;
    v = '0;
    lim = (depth_reg > CAP) ? CAP : depth_reg;
    for (int i = 0; i < hist_fill && picked.size() < lim; i++) begin
      tmp = lap_hist[(hist_pos + CAP - 1 - i) % CAP];
      if (tmp != 0) picked.push_back(tmp);
    end
    if (picked.size() >= MIN_JUDGE) begin
      picked.sort();
      v.judged = 1'b1;
      if (picked.size() % 2) begin
        v.median = picked[picked.size() / 2];
      end else begin
        prod = ({32'd0, picked[picked.size() / 2 - 1]} + {32'd0, picked[picked.size() / 2]}) >> 1;
        v.median = prod[31:0];
      end
      pct = (ratio_reg > 100) ? 100 : ratio_reg;
      abs_fl = (v.median > margin_reg) ? v.median - margin_reg : '0;
      prod = ({32'd0, v.median} * pct) / 100;
      rat_fl = prod[31:0];
      fl = (abs_fl > rat_fl) ? abs_fl : rat_fl;
      v.outlier = lap < fl;
    end
    lap_hist[hist_pos] = lap;
    hist_pos = (hist_pos + 1) % CAP;
    if (hist_fill < CAP) hist_fill++;
    return v;
  endfunction

  // send one lap, with a random gap first unless no_gap is set
  task automatic send_lap(logic [LAP_W-1:0] lap, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= lap;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    verdict_q.push_back(judge_lap(lap));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [LAP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_DEPTH: depth_reg = val[DEPTH_W-1:0];
      REG_FAST_MARGIN:  margin_reg = val;
      REG_FAST_RATIO:   ratio_reg = val[PCT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random lap: mostly near a base, some outliers, zeros and extremes
  function automatic logic [LAP_W-1:0] rand_lap(logic [LAP_W-1:0] base);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return base / 2 + $urandom_range(0, 100);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return base + $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // receiver: per-item wait, or one long hold when requested
  initial begin : receiver
    int wait_n;
    int hold_seen;
    hold_seen = 0;
    @(posedge clk);
    forever begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        wait_n = HOLD_LEN;
      end else begin
        wait_n = stall_enable ? $urandom_range(0, 9) : 0;
      end
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // result checker
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result with no expectation: %h", out_tdata);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_tdata[0] !== exp_v.outlier) begin
          $error("is_outlier exp %0d got %0d", exp_v.outlier, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== exp_v.judged) begin
          $error("judged exp %0d got %0d", exp_v.judged, out_tdata[1]);
          errors++;
        end
        if (out_tdata[33:2] !== exp_v.median) begin
          $error("window_median_ms exp %0d got %0d", exp_v.median, out_tdata[33:2]);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_lap(32'd0);
    send_lap(32'd60000);
    send_lap(32'd61000);
    send_lap(32'd59000);
    send_lap(32'd62000);
    send_lap(32'd20000);
    send_lap(32'd0);
    send_lap(32'hFFFF_FFFF);
    send_lap(32'hFFFF_FFFE);
    send_lap(32'd1);
    send_lap(32'hFFFF_FFFF);
    send_lap(32'hAAAA_AAAA);
    send_lap(32'h5555_5555);
    send_lap(32'd60500);
    drain_results();
  endtask

  task automatic test_config_sweep();
    logic [LAP_W-1:0] margins [4] = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'h8000_0000};
    logic [DEPTH_W-1:0] depths [5] = '{7'd0, 7'd4, 7'd127, 7'd64, 7'd5};
    logic [PCT_W-1:0] ratios [5] = '{7'd0, 7'd100, 7'd127, 7'd101, 7'd90};
    logic [LAP_W-1:0] base;
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_WINDOW_DEPTH, (ph < 5) ? depths[ph] : $urandom_range(0, 127));
      write_reg(REG_FAST_MARGIN, (ph < 4) ? margins[ph] : $urandom());
      write_reg(REG_FAST_RATIO, (ph < 5) ? ratios[ph] : $urandom_range(0, 127));
      base = (ph % 3 == 0) ? $urandom() : $urandom_range(1000, 200000);
      for (int i = 0; i < 100; i++) send_lap(rand_lap(base));
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_WINDOW_DEPTH, 7'd16);
    hold_seq++;
    for (int i = 0; i < 12; i++) send_lap(rand_lap(32'd90000), 1);
    drain_results();
    stall_enable = 1'b0;
    for (int i = 0; i < 10; i++) send_lap(rand_lap(32'd90000), 1);
    drain_results();
    stall_enable = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < CAP; i++) lap_hist[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
